// ===== rtl/msrt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and control structs for the missing segment retry tracker.
// No dependencies; every other file refers to this package by scoped names.
package msrt_pkg;

  localparam int unsigned SEGMENTS = 96;
  localparam int unsigned NODES    = 3;

  // map index and missing count widths
  localparam int unsigned IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned SEG_W = $clog2(SEGMENTS + 1);

  // item field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned NODE_W = 2;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned NUM_W  = 7;
  localparam int unsigned TOT_W  = 7;

  // configuration
  localparam int unsigned PLIM_W     = 6;
  localparam int unsigned SLIM_W     = 8;
  localparam int unsigned PLIM_MAX   = 32;
  localparam int unsigned PLIM_RESET = 32;
  localparam int unsigned SLIM_RESET = 20;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic REG_PATCH_LIMIT = 1'b0;
  localparam logic REG_STALL_LIMIT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_NEW_ROUND,
    OP_START,
    OP_SEGMENT,
    OP_TICK
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUMMON,
    KIND_RESEND,
    KIND_REPORT
  } kind_e;

  typedef struct packed {
    logic [PLIM_W-1:0] patch_limit;
    logic [SLIM_W-1:0] stall_limit;
  } cfg_t;

  typedef struct packed {
    logic clear;  // zero the map, missing count back to SEGMENTS
    logic shift;  // rotate the map by one bit
    logic mark;   // set the head bit as it rotates past
  } map_cmd_t;

  typedef struct packed {
    logic             head;
    logic [SEG_W-1:0] miss;
  } map_stat_t;

endpackage

// ===== rtl/msrt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tracker's input and result items.
// Depends on msrt_pkg for field widths.
interface msrt_in_if;
  logic                        valid;
  logic                        ready;
  logic [msrt_pkg::OP_W-1:0]   operation;
  logic [msrt_pkg::NODE_W-1:0] node_id;
  logic [msrt_pkg::POS_W-1:0]  segment_pos;

  modport source (output valid, operation, node_id, segment_pos, input ready);
  modport sink   (input valid, operation, node_id, segment_pos, output ready);
endinterface

interface msrt_out_if;
  logic                        valid;
  logic                        ready;
  logic [msrt_pkg::KIND_W-1:0] kind;
  logic [msrt_pkg::NODE_W-1:0] node;
  logic [msrt_pkg::NUM_W-1:0]  segment_number;
  logic [msrt_pkg::TOT_W-1:0]  received_total;
  logic                        all_acked;
  logic                        last;

  modport source (output valid, kind, node, segment_number, received_total, all_acked, last,
                  input ready);
  modport sink   (input valid, kind, node, segment_number, received_total, all_acked, last,
                  output ready);
endinterface

// ===== rtl/msrt_apb.sv =====
`timescale 1ns / 1ps
// APB configuration registers: patch limit and stall limit.
// Depends on msrt_pkg.
module msrt_apb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msrt_pkg::APB_AW-1:0]   paddr,
  input  logic [msrt_pkg::APB_DW-1:0]   pwdata,
  output logic [msrt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output msrt_pkg::cfg_t                cfg_o
);

  msrt_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        msrt_pkg::REG_PATCH_LIMIT: cfg_d.patch_limit = pwdata[msrt_pkg::PLIM_W-1:0];
        msrt_pkg::REG_STALL_LIMIT: cfg_d.stall_limit = pwdata[msrt_pkg::SLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      msrt_pkg::REG_PATCH_LIMIT: prdata = msrt_pkg::APB_DW'(cfg_q.patch_limit);
      msrt_pkg::REG_STALL_LIMIT: prdata = msrt_pkg::APB_DW'(cfg_q.stall_limit);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.patch_limit <= msrt_pkg::PLIM_W'(msrt_pkg::PLIM_RESET);
      cfg_q.stall_limit <= msrt_pkg::SLIM_W'(msrt_pkg::SLIM_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/msrt_map.sv =====
`timescale 1ns / 1ps
// Received-segment map as a rotating bit-serial shift register with a missing count.
// Depends on msrt_pkg. The head bit is the entry at the controller's pass index.
module msrt_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msrt_pkg::map_cmd_t  cmd_i,
  output msrt_pkg::map_stat_t stat_o
);

  logic [msrt_pkg::SEGMENTS-1:0] map_q, map_d;
  logic [msrt_pkg::SEG_W-1:0]    miss_q, miss_d;
  logic                          head;

  assign head = map_q[0];

  always_comb begin
    map_d  = map_q;
    miss_d = miss_q;
    if (cmd_i.clear) begin
      map_d  = '0;
      miss_d = msrt_pkg::SEG_W'(msrt_pkg::SEGMENTS);
    end else if (cmd_i.shift) begin
      // a full pass of SEGMENTS shifts brings the map back to its home alignment
      map_d = {head | cmd_i.mark, map_q[msrt_pkg::SEGMENTS-1:1]};
      if (cmd_i.mark && !head) begin
        miss_d = miss_q - msrt_pkg::SEG_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q  <= '0;
      miss_q <= msrt_pkg::SEG_W'(msrt_pkg::SEGMENTS);
    end else begin
      map_q  <= map_d;
      miss_q <= miss_d;
    end
  end

  assign stat_o.head = head;
  assign stat_o.miss = miss_q;

endmodule

// ===== rtl/msrt_ctrl.sv =====
`timescale 1ns / 1ps
// Round/node sequencer: decodes items, runs map passes, builds results in an output register.
// Depends on msrt_pkg, msrt_if and the map status from msrt_map.
module msrt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  msrt_in_if.sink             in_i,
  msrt_out_if.source          out_o,
  input  msrt_pkg::cfg_t      cfg_i,
  output msrt_pkg::map_cmd_t  map_cmd_o,
  input  msrt_pkg::map_stat_t map_stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUMMON,
    ST_MARK,
    ST_SCAN,
    ST_REPORT
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_SUMMON,
    MD_PATCH
  } mode_e;

  state_e                            state_q, state_d;
  mode_e                             mode_q, mode_d;
  logic [msrt_pkg::NODE_W-1:0]       cur_q, cur_d;
  logic [msrt_pkg::NODES-1:0]        acked_q, acked_d;
  logic [msrt_pkg::SEG_W-1:0]        prev_q, prev_d;
  logic [msrt_pkg::SLIM_W-1:0]       stall_q, stall_d;
  logic [msrt_pkg::IDX_W-1:0]        cnt_q, cnt_d;
  logic [msrt_pkg::IDX_W-1:0]        pos_q, pos_d;
  logic [msrt_pkg::PLIM_W-1:0]       emit_q, emit_d;
  logic [msrt_pkg::PLIM_W-1:0]       nemit_q, nemit_d;
  logic                              done_q, done_d;

  logic                              ov_q, ov_d;
  msrt_pkg::kind_e                   okind_q, okind_d;
  logic [msrt_pkg::NODE_W-1:0]       onode_q, onode_d;
  logic [msrt_pkg::NUM_W-1:0]        oseg_q, oseg_d;
  logic [msrt_pkg::TOT_W-1:0]        otot_q, otot_d;
  logic                              oall_q, oall_d;
  logic                              olast_q, olast_d;

  logic                              in_ready;
  logic                              accept;
  logic                              out_free;
  msrt_pkg::op_e                     op;
  logic [msrt_pkg::NODES-1:0]        nid_hit;
  logic [msrt_pkg::NODES-1:0]        cur_hit;
  logic [msrt_pkg::NODES-1:0]        acked_new;
  logic [msrt_pkg::SEG_W-1:0]        lost;
  logic [msrt_pkg::PLIM_W-1:0]       lim;
  logic [msrt_pkg::PLIM_W-1:0]       nemit;
  logic [msrt_pkg::SLIM_W-1:0]       stall_inc;
  logic                              same;
  logic                              give_up;
  logic                              want;
  logic                              pass_end;
  logic                              pos_ok;

  assign in_ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_ready;
  assign out_free = !ov_q || out_o.ready;
  assign op       = msrt_pkg::op_e'(in_i.operation);
  assign lost     = map_stat_i.miss;
  assign pass_end = (cnt_q == msrt_pkg::IDX_W'(msrt_pkg::SEGMENTS - 1));
  assign pos_ok   = (in_i.segment_pos != '0) &&
                    (32'(in_i.segment_pos) <= msrt_pkg::SEGMENTS);

  always_comb begin
    for (int i = 0; i < msrt_pkg::NODES; i++) begin
      nid_hit[i] = (in_i.node_id == msrt_pkg::NODE_W'(i + 1));
      cur_hit[i] = (cur_q == msrt_pkg::NODE_W'(i + 1));
    end
  end
  assign acked_new = acked_q | cur_hit;

  // patch limit clamped to 1..PLIM_MAX
  always_comb begin
    if (cfg_i.patch_limit == '0) begin
      lim = msrt_pkg::PLIM_W'(1);
    end else if (32'(cfg_i.patch_limit) > msrt_pkg::PLIM_MAX) begin
      lim = msrt_pkg::PLIM_W'(msrt_pkg::PLIM_MAX);
    end else begin
      lim = cfg_i.patch_limit;
    end
  end

  assign nemit     = (msrt_pkg::SEG_W'(lim) < lost) ? lim : msrt_pkg::PLIM_W'(lost);
  assign stall_inc = (stall_q == '1) ? stall_q : stall_q + msrt_pkg::SLIM_W'(1);
  assign same      = (lost == prev_q);
  assign give_up   = same && (stall_inc > cfg_i.stall_limit);
  assign want      = !map_stat_i.head && (emit_q < nemit_q);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    cur_d     = cur_q;
    acked_d   = acked_q;
    prev_d    = prev_q;
    stall_d   = stall_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    emit_d    = emit_q;
    nemit_d   = nemit_q;
    done_d    = done_q;
    ov_d      = ov_q && !out_o.ready;
    okind_d   = okind_q;
    onode_d   = onode_q;
    oseg_d    = oseg_q;
    otot_d    = otot_q;
    oall_d    = oall_q;
    olast_d   = olast_q;
    map_cmd_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            msrt_pkg::OP_NEW_ROUND: begin
              acked_d = '0;
            end
            msrt_pkg::OP_START: begin
              if (mode_q == MD_IDLE && (|nid_hit) && !(|(nid_hit & acked_q))) begin
                cur_d           = in_i.node_id;
                mode_d          = MD_SUMMON;
                map_cmd_o.clear = 1'b1;
                state_d         = ST_SUMMON;
              end
            end
            msrt_pkg::OP_SEGMENT: begin
              if (in_i.node_id == cur_q && pos_ok) begin
                pos_d   = msrt_pkg::IDX_W'(in_i.segment_pos - msrt_pkg::POS_W'(1));
                cnt_d   = '0;
                state_d = ST_MARK;
              end
            end
            msrt_pkg::OP_TICK: begin
              if (mode_q == MD_SUMMON && lost == msrt_pkg::SEG_W'(msrt_pkg::SEGMENTS)) begin
                // nothing arrived yet: just move on to patching
                mode_d = MD_PATCH;
              end else if (mode_q == MD_SUMMON && lost == '0) begin
                state_d = ST_REPORT;
              end else if (mode_q != MD_IDLE) begin
                mode_d = MD_PATCH;
                if (same) begin
                  stall_d = give_up ? '0 : stall_inc;
                  if (give_up) begin
                    prev_d = '0;
                  end
                end else begin
                  prev_d  = lost;
                  stall_d = '0;
                end
                if (lost == '0) begin
                  prev_d  = '0;
                  state_d = ST_REPORT;
                end else begin
                  nemit_d = nemit;
                  emit_d  = '0;
                  cnt_d   = '0;
                  done_d  = give_up;
                  state_d = ST_SCAN;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_SUMMON: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = msrt_pkg::KIND_SUMMON;
          onode_d = cur_q;
          oseg_d  = '0;
          otot_d  = '0;
          oall_d  = 1'b0;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_MARK: begin
        map_cmd_o.shift = 1'b1;
        map_cmd_o.mark  = (cnt_q == pos_q);
        cnt_d           = pass_end ? '0 : cnt_q + msrt_pkg::IDX_W'(1);
        if (pass_end) begin
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        // hold the map still while a resend entry waits for the output slot
        if (!(want && !out_free)) begin
          map_cmd_o.shift = 1'b1;
          cnt_d           = pass_end ? '0 : cnt_q + msrt_pkg::IDX_W'(1);
          if (want) begin
            ov_d    = 1'b1;
            okind_d = msrt_pkg::KIND_RESEND;
            onode_d = cur_q;
            oseg_d  = msrt_pkg::NUM_W'(msrt_pkg::SEG_W'(cnt_q) + msrt_pkg::SEG_W'(1));
            otot_d  = '0;
            oall_d  = 1'b0;
            olast_d = (emit_q + msrt_pkg::PLIM_W'(1) == nemit_q) && !done_q;
            emit_d  = emit_q + msrt_pkg::PLIM_W'(1);
          end
          if (pass_end) begin
            state_d = done_q ? ST_REPORT : ST_IDLE;
          end
        end
      end

      ST_REPORT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = msrt_pkg::KIND_REPORT;
          onode_d = cur_q;
          oseg_d  = '0;
          otot_d  = msrt_pkg::TOT_W'(msrt_pkg::SEG_W'(msrt_pkg::SEGMENTS) - lost);
          oall_d  = &acked_new;
          olast_d = 1'b1;
          acked_d = acked_new;
          mode_d  = MD_IDLE;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MD_IDLE;
      cur_q   <= '0;
      acked_q <= '0;
      prev_q  <= '0;
      stall_q <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      emit_q  <= '0;
      nemit_q <= '0;
      done_q  <= 1'b0;
      ov_q    <= 1'b0;
      okind_q <= msrt_pkg::KIND_SUMMON;
      onode_q <= '0;
      oseg_q  <= '0;
      otot_q  <= '0;
      oall_q  <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cur_q   <= cur_d;
      acked_q <= acked_d;
      prev_q  <= prev_d;
      stall_q <= stall_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      emit_q  <= emit_d;
      nemit_q <= nemit_d;
      done_q  <= done_d;
      ov_q    <= ov_d;
      okind_q <= okind_d;
      onode_q <= onode_d;
      oseg_q  <= oseg_d;
      otot_q  <= otot_d;
      oall_q  <= oall_d;
      olast_q <= olast_d;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = ov_q;
  assign out_o.kind           = okind_q;
  assign out_o.node           = onode_q;
  assign out_o.segment_number = oseg_q;
  assign out_o.received_total = otot_q;
  assign out_o.all_acked      = oall_q;
  assign out_o.last           = olast_q;

`ifndef SYNTHESIS
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> emit_q <= nemit_q)
    else $error("resend count exceeds the planned number of entries");

  a_resend_on_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && map_cmd_o.shift && want)
      |=> (out_o.valid && out_o.kind == msrt_pkg::KIND_RESEND))
    else $error("missing segment passed without a resend entry");

  a_pass_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN || state_q == ST_MARK) && state_d != state_q) |-> pass_end)
    else $error("map pass left before a full rotation");

  a_report_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPORT && out_free) |=> (mode_q == MD_IDLE && out_o.last && out_o.valid))
    else $error("completion report did not close the node");
`endif

endmodule

// ===== rtl/missing_segment_retry_tracker.sv =====
`timescale 1ns / 1ps
// Missing segment retry tracker: top level tying the APB registers, map and sequencer.
// Depends on msrt_pkg, msrt_if, msrt_apb, msrt_map and msrt_ctrl.
//
// Usage:
//   in_i   valid/ready channel of items (operation, node_id, segment_pos).
//   out_o  valid/ready channel of result items (summon, resend entries, completion
//          report); the last result of an item carries last = 1.
//   APB    patch_limit at 0x0, stall_limit at 0x4; write only while idle.
// Operation: a start item leads to its summon request. The map is a 96-bit
//   rotating shift register looked at one bit per cycle unless a resend entry
//   waits on a stalled receiver. A segment-received item runs one map pass; a
//   tick in patch mode, or in summon mode once something arrived, runs one pass
//   and, on give-up, the completion report, or only the report if nothing is
//   missing. Other ticks at most change the mode. One item is processed at a time.
// Results go through a single output register; the next item is accepted while
//   a result still waits there. When the receiver stalls, the map pass halts on
//   the pending missing segment until the register frees up.
// Reset: all nodes unacknowledged, mode idle, map clear, limits 32 and 20.
module missing_segment_retry_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  msrt_in_if.sink                       in_i,
  msrt_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msrt_pkg::APB_AW-1:0]   paddr,
  input  logic [msrt_pkg::APB_DW-1:0]   pwdata,
  output logic [msrt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  msrt_pkg::cfg_t      cfg;
  msrt_pkg::map_cmd_t  map_cmd;
  msrt_pkg::map_stat_t map_stat;

  msrt_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  msrt_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (map_cmd),
    .stat_o (map_stat)
  );

  msrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_i      (cfg),
    .map_cmd_o  (map_cmd),
    .map_stat_i (map_stat)
  );

endmodule
